/* src/lee_pkg.sv */
package lee_pkg;

    localparam int NODES_MAX   = 4;
    localparam int FACTS       = NODES_MAX - 1;
    localparam int NUM_W       = 128;
    localparam int DEN_W       = 96;
    localparam int TERM_W      = NUM_W + 1;
    localparam int PAIR_W      = TERM_W + 1;
    localparam int SUM_W       = TERM_W + 2;
    localparam int LANE_STAGES = 6;
    localparam int DIV_STEPS   = NUM_W;
    localparam int SIDE_LEN    = LANE_STAGES + DIV_STEPS + 3;

    localparam logic [31:0] ONE_FACTOR = 32'd1;
    localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]         node_count;
        logic signed [31:0] node_pos_0;
        logic signed [31:0] node_pos_1;
        logic signed [31:0] node_pos_2;
        logic signed [31:0] node_pos_3;
        logic signed [31:0] node_val_0;
        logic signed [31:0] node_val_1;
        logic signed [31:0] node_val_2;
        logic signed [31:0] node_val_3;
        logic signed [31:0] sample_point;
        logic               last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               dup_node_error;
        logic               last_out;
    } t_out_item;

    typedef struct packed {
        logic dup;
        logic last;
    } t_tag;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } t_div_st;

    // One restoring step: shift in the next numerator bit, subtract if it fits.
    function automatic t_div_st div_step(input t_div_st st, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        t_div_st        r;
        t     = {st.rem, st.nq[NUM_W-1]};
        d     = t - {1'b0, den};
        r.nq  = {st.nq[NUM_W-2:0], ~d[DEN_W]};
        r.rem = d[DEN_W] ? t[DEN_W-1:0] : d[DEN_W-1:0];
        return r;
    endfunction

endpackage

/* src/lee_lane.sv */
module lee_lane #(
    parameter int unsigned LANE = 0
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  lee_pkg::t_in_item        i_item,
    input  logic [2:0]               i_n_eff,
    output logic [lee_pkg::NUM_W-1:0] o_num,
    output logic [lee_pkg::DEN_W-1:0] o_den,
    output logic                     o_neg
);
    import lee_pkg::*;

    logic signed [31:0] pos [NODES_MAX];
    logic signed [31:0] val [NODES_MAX];
    logic [31:0]        n_vm;
    logic [31:0]        n_f [FACTS];
    logic [31:0]        n_g [FACTS];
    logic               n_neg;

    // stage 1: factor magnitudes
    logic [31:0]  r_vm;
    logic [31:0]  r_f [FACTS];
    logic [31:0]  r_g [FACTS];
    logic         r_neg1;
    // stage 2: first products
    logic [63:0]  r_p1, r_q1;
    logic [31:0]  r_f1_2, r_f2_2, r_g2_2;
    logic         r_neg2;
    // stage 3: partial products
    logic [63:0]  r_pp0, r_pp1, r_qq0, r_qq1;
    logic [31:0]  r_f2_3;
    logic         r_neg3;
    // stage 4: 96-bit products
    logic [95:0]  r_p2, r_den4;
    logic [31:0]  r_f2_4;
    logic         r_neg4;
    // stage 5: partial products of the last factor
    logic [63:0]  r_r0, r_r1, r_r2;
    logic [95:0]  r_den5;
    logic         r_neg5;
    // stage 6: full numerator
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    always_comb begin
        logic               keep;
        logic               use_i;
        logic [1:0]         idx;
        logic signed [32:0] dx;
        logic signed [32:0] dg;
        logic signed [31:0] v;
        pos = '{i_item.node_pos_0, i_item.node_pos_1, i_item.node_pos_2, i_item.node_pos_3};
        val = '{i_item.node_val_0, i_item.node_val_1, i_item.node_val_2, i_item.node_val_3};
        keep  = (3'(LANE) < i_n_eff);
        v     = val[2'(LANE)];
        n_vm  = keep ? (v[31] ? (~v + 32'd1) : v) : 32'd0;
        n_neg = keep & v[31];
        for (int k = 0; k < FACTS; k++) begin
            idx   = (k < int'(LANE)) ? 2'(k) : 2'(k + 1);
            use_i = keep && (3'(idx) < i_n_eff);
            dx    = 33'(i_item.sample_point) - 33'(pos[idx]);
            dg    = 33'(pos[2'(LANE)]) - 33'(pos[idx]);
            if (use_i) begin
                n_f[k] = dx[32] ? 32'(-dx) : dx[31:0];
                n_g[k] = dg[32] ? 32'(-dg) : dg[31:0];
                n_neg  = n_neg ^ dx[32] ^ dg[32];
            end else begin
                n_f[k] = ONE_FACTOR;
                n_g[k] = ONE_FACTOR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vm   <= n_vm;
            r_f    <= n_f;
            r_g    <= n_g;
            r_neg1 <= n_neg;

            r_p1   <= 64'(r_vm) * 64'(r_f[0]);
            r_q1   <= 64'(r_g[0]) * 64'(r_g[1]);
            r_f1_2 <= r_f[1];
            r_f2_2 <= r_f[2];
            r_g2_2 <= r_g[2];
            r_neg2 <= r_neg1;

            r_pp0  <= 64'(r_p1[31:0]) * 64'(r_f1_2);
            r_pp1  <= 64'(r_p1[63:32]) * 64'(r_f1_2);
            r_qq0  <= 64'(r_q1[31:0]) * 64'(r_g2_2);
            r_qq1  <= 64'(r_q1[63:32]) * 64'(r_g2_2);
            r_f2_3 <= r_f2_2;
            r_neg3 <= r_neg2;

            r_p2   <= 96'(r_pp0) + {r_pp1, 32'd0};
            r_den4 <= 96'(r_qq0) + {r_qq1, 32'd0};
            r_f2_4 <= r_f2_3;
            r_neg4 <= r_neg3;

            r_r0   <= 64'(r_p2[31:0]) * 64'(r_f2_4);
            r_r1   <= 64'(r_p2[63:32]) * 64'(r_f2_4);
            r_r2   <= 64'(r_p2[95:64]) * 64'(r_f2_4);
            r_den5 <= r_den4;
            r_neg5 <= r_neg4;

            r_num  <= NUM_W'(r_r0) + {32'd0, r_r1, 32'd0} + {r_r2, 64'd0};
            r_den  <= r_den5;
            r_neg  <= r_neg5;
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;
    assign o_neg = r_neg;

endmodule

/* src/lee_div.sv */
module lee_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [lee_pkg::NUM_W-1:0] i_num,
    input  logic [lee_pkg::DEN_W-1:0] i_den,
    input  logic                      i_neg,
    output logic [lee_pkg::NUM_W-1:0] o_quot,
    output logic                      o_neg
);
    import lee_pkg::*;

    t_div_st          r_st  [DIV_STEPS];
    logic [DEN_W-1:0] r_den [DIV_STEPS];
    logic             r_neg [DIV_STEPS];
    t_div_st          first;

    assign first.rem = '0;
    assign first.nq  = i_num;

    // one quotient bit per stage, MSB first
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]  <= div_step(first, i_den);
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_st[s]  <= div_step(r_st[s-1], r_den[s-1]);
                r_den[s] <= r_den[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    assign o_quot = r_st[DIV_STEPS-1].nq;
    assign o_neg  = r_neg[DIV_STEPS-1];

endmodule

/* src/lagrange_element_eval.sv */
// Lagrange element evaluator.
// Input channel: i_in_valid / i_in_item / o_in_stall. Output channel:
// o_out_valid / o_out_item / i_out_stall. An item moves on an edge where
// valid is high and stall is low.
// Each item holds up to four nodes (position, value) and a sample point,
// all signed Q16.16; the result is sum_j trunc(v_j * N_j / D_j), saturated
// to 32 bits, or 0 with dup_node_error set when two used nodes coincide.
// Throughput: one item per cycle, sustained while the receiver does not stall.
// Path from acceptance to o_out_valid: the input register, 6 multiplier-chain
// stages, the 128-stage restoring divider (one quotient bit per stage for a
// 128-bit numerator), 3 sign/sum stages and the output register.
// Each term has its own lane (multiplier chain + divider); NODES lanes exist.
// Reset (synchronous, active low) clears every valid bit; payload
// registers are not reset.
// When the receiver stalls, the output register holds its item and one
// more item lands in a skid register; only then does o_in_stall rise and
// the whole pipeline freeze. o_in_stall is a register output.
module lagrange_element_eval #(
    parameter int NODES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lee_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output lee_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import lee_pkg::*;

    logic en;

    // input register
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic [2:0] n_eff;
    logic      dup;

    // valid bits and side info travelling with the data
    logic r_vld [SIDE_LEN];
    t_tag r_tag [SIDE_LEN];

    // lane outputs
    logic [NUM_W-1:0] quot [NODES_MAX];
    logic             qneg [NODES_MAX];

    // sign, sum, output
    logic signed [TERM_W-1:0] r_term [NODES_MAX];
    logic signed [PAIR_W-1:0] r_sa0, r_sa1;
    logic signed [SUM_W-1:0]  r_sb;
    logic [31:0]              sat;
    t_out_item                res;
    logic                     prod, take;

    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_out, n_out;
    t_out_item r_skid, n_skid;

    assign en = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_item <= i_in_item;
        end
    end

    // node count clamped to the lanes present
    assign n_eff = (r_in_item.node_count > 3'(NODES)) ? 3'(NODES) : r_in_item.node_count;

    always_comb begin
        logic signed [31:0] pos [NODES_MAX];
        pos = '{r_in_item.node_pos_0, r_in_item.node_pos_1,
                r_in_item.node_pos_2, r_in_item.node_pos_3};
        dup = 1'b0;
        for (int j = 1; j < NODES_MAX; j++) begin
            for (int i = 0; i < j; i++) begin
                if ((3'(j) < n_eff) && (pos[i] == pos[j])) begin
                    dup = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_LEN; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= r_in_valid;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0].dup  <= dup;
            r_tag[0].last <= r_in_item.last_in;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // one lane per node: products, then the divider
    for (genvar j = 0; j < NODES_MAX; j++) begin : g_lane
        if (j < NODES) begin : g_on
            logic [NUM_W-1:0] num;
            logic [DEN_W-1:0] den;
            logic             neg;

            lee_lane #(.LANE(j)) u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_item (r_in_item),
                .i_n_eff(n_eff),
                .o_num  (num),
                .o_den  (den),
                .o_neg  (neg)
            );

            lee_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (num),
                .i_den (den),
                .i_neg (neg),
                .o_quot(quot[j]),
                .o_neg (qneg[j])
            );
        end else begin : g_off
            assign quot[j] = '0;
            assign qneg[j] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NODES_MAX; j++) begin
                r_term[j] <= qneg[j] ? -$signed({1'b0, quot[j]}) : $signed({1'b0, quot[j]});
            end
            r_sa0 <= PAIR_W'(r_term[0]) + PAIR_W'(r_term[1]);
            r_sa1 <= PAIR_W'(r_term[2]) + PAIR_W'(r_term[3]);
            r_sb  <= SUM_W'(r_sa0) + SUM_W'(r_sa1);
        end
    end

    // saturate: fits when bits above 31 all copy the sign
    always_comb begin
        if ((&r_sb[SUM_W-1:31]) || ~(|r_sb[SUM_W-1:31])) begin
            sat = r_sb[31:0];
        end else begin
            sat = r_sb[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end
        res.interp_value   = r_tag[SIDE_LEN-1].dup ? 32'sd0 : $signed(sat);
        res.dup_node_error = r_tag[SIDE_LEN-1].dup;
        res.last_out       = r_tag[SIDE_LEN-1].last;
    end

    assign prod = en & r_vld[SIDE_LEN-1];
    assign take = r_out_valid & ~i_out_stall;

    // output register plus skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (prod) begin
            if (!r_out_valid || take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* tb/lee_checker.sv */
module lee_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lee_pkg::t_in_item  i_in_item,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  lee_pkg::t_out_item i_out_item,
    input  logic               i_out_stall,
    output int                 o_fail_count,
    output int                 o_pending
);
    import lee_pkg::*;

    localparam logic signed [199:0] Q_HI = 200'sd2147483647;
    localparam logic signed [199:0] Q_LO = -200'sd2147483648;

    t_out_item expected_results[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    // Exact-integer Lagrange sum, truncating each term toward zero.
    function automatic t_out_item eval_sample(input t_in_item it);
        logic signed [31:0]  pos [NODES_MAX];
        logic signed [31:0]  val [NODES_MAX];
        logic signed [199:0] num, den, dx, sum;
        int                  n;
        logic                dup;
        t_out_item           r;
        pos = '{it.node_pos_0, it.node_pos_1, it.node_pos_2, it.node_pos_3};
        val = '{it.node_val_0, it.node_val_1, it.node_val_2, it.node_val_3};
        n   = (it.node_count > NODES_MAX) ? NODES_MAX : int'(it.node_count);
        dup = 1'b0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (pos[i] == pos[j]) dup = 1'b1;
        sum = '0;
        if (!dup) begin
            for (int j = 0; j < n; j++) begin
                num = val[j];
                den = 1;
                for (int i = 0; i < n; i++) begin
                    if (i == j) continue;
                    dx  = it.sample_point;
                    dx  = dx - pos[i];
                    num = num * dx;
                    dx  = pos[j];
                    dx  = dx - pos[i];
                    den = den * dx;
                end
                sum = sum + num / den;
            end
        end
        if (sum > Q_HI)      r.interp_value = SAT_MAX;
        else if (sum < Q_LO) r.interp_value = SAT_MIN;
        else                 r.interp_value = sum[31:0];
        r.dup_node_error = dup;
        r.last_out       = it.last_in;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            expected_results.push_back(eval_sample(i_in_item));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", i_out_item.interp_value, 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (i_out_item.interp_value !== want.interp_value)
                    report_mismatch("interp_value", i_out_item.interp_value,
                                    want.interp_value);
                if (i_out_item.dup_node_error !== want.dup_node_error)
                    report_mismatch("dup_node_error", 32'(i_out_item.dup_node_error),
                                    32'(want.dup_node_error));
                if (i_out_item.last_out !== want.last_out)
                    report_mismatch("last_out", 32'(i_out_item.last_out),
                                    32'(want.last_out));
            end
        end
    end

endmodule

/* tb/tb_top.sv */
module tb_top;
    import lee_pkg::*;

    localparam int RANDOM_ITEMS = 630;
    localparam int QUIET_ITEMS  = 80;     // tail of the run with no idling
    localparam int STUCK_LIMIT  = 4000;   // cycles with no item moving

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;
    logic      quiet = 1'b0;
    int        fail_count, pending;
    int        stuck_cycles = 0;

    always #2 i_clk = ~i_clk;

    lagrange_element_eval dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    lee_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_item    (in_item),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_item   (out_item),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver back-pressure: random stall bursts, alternating with free runs.
    always @(negedge i_clk) begin
        int len;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, 18);
            out_stall <= 1'b1;
            repeat (len) @(negedge i_clk);
            out_stall <= 1'b0;
        end
    end

    // Watchdog: trips when neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL lagrange_element_eval");
            $finish;
        end
    end

    // Present one item, hold it until accepted, then maybe idle a while.
    task automatic send_sample(input t_in_item it);
        int gap;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Position drawn from full range, or a narrow window so terms stay in range.
    function automatic logic [31:0] pick_coord(input bit narrow);
        if (narrow) return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
        return $urandom;
    endfunction

    function automatic t_in_item random_sample();
        t_in_item it;
        bit       narrow;
        int       kind;
        logic [31:0] p [4];
        narrow = $urandom_range(0, 2) != 0;
        kind   = $urandom_range(0, 19);
        for (int k = 0; k < 4; k++) begin
            // distinct nodes with good probability; a repeat of an earlier node is nudged
            p[k] = pick_coord(narrow);
            for (int m = 0; m < k; m++)
                if (p[k] == p[m]) p[k] = p[k] + 32'd7919 * (k + 1);
        end
        if (kind == 0) p[$urandom_range(1, 3)] = p[0];              // repeated node
        it.node_count   = (kind == 1) ? 3'($urandom_range(5, 7))
                                      : (kind == 2) ? 3'd0 : 3'($urandom_range(1, 4));
        it.node_pos_0   = p[0];
        it.node_pos_1   = p[1];
        it.node_pos_2   = p[2];
        it.node_pos_3   = p[3];
        it.node_val_0   = pick_coord(narrow);
        it.node_val_1   = pick_coord(narrow);
        it.node_val_2   = pick_coord(narrow);
        it.node_val_3   = pick_coord(narrow);
        it.sample_point = ($urandom_range(0, 4) == 0) ? p[$urandom_range(0, 3)]
                                                      : pick_coord(narrow);
        it.last_in      = $urandom_range(0, 7) == 0;
        return it;
    endfunction

    function automatic t_in_item make_sample(input logic [2:0] n, input logic [31:0] p0,
            input logic [31:0] p1, input logic [31:0] p2, input logic [31:0] p3,
            input logic [31:0] v, input logic [31:0] x, input logic last);
        t_in_item it;
        it = '{n, p0, p1, p2, p3, v, ~v, v ^ 32'h5555_5555, 32'sh0001_0000, x, last};
        return it;
    endfunction

    initial begin
        t_in_item directed [$];
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero nodes, single node (weight 1.0), clamp of count above four
        directed.push_back(make_sample(3'd0, 1, 2, 3, 4, 32'h7FFF_FFFF, 0, 1'b0));
        directed.push_back(make_sample(3'd1, 32'h8000_0000, 0, 0, 0, 32'h8000_0000,
                                       32'h7FFF_FFFF, 1'b1));
        directed.push_back(make_sample(3'd1, 5, 5, 5, 5, 32'h7FFF_FFFF, 0, 1'b0));
        directed.push_back(make_sample(3'd7, 0, 32'h0001_0000, 32'h0002_0000,
                                       32'h0003_0000, 32'h0004_0000, 32'h0001_8000, 1'b0));
        directed.push_back(make_sample(3'd5, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1,
                                       32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        // repeated nodes, including one beyond the count that must be ignored
        directed.push_back(make_sample(3'd2, 9, 9, 1, 2, 32'h1234_5678, 3, 1'b0));
        directed.push_back(make_sample(3'd4, 1, 2, 3, 1, 32'h1234_5678, 3, 1'b1));
        directed.push_back(make_sample(3'd3, 1, 2, 3, 1, 32'h1234_5678, 3, 1'b0));
        directed.push_back(make_sample(3'd4, 32'h8000_0000, 32'h8000_0000, 0, 1,
                                       32'hFFFF_FFFF, 0, 1'b0));
        // nodes clustered at one end or spread across the range, sample at a far end: forces saturation both ways
        directed.push_back(make_sample(3'd4, 32'h8000_0000, 32'h8000_0001,
                                       32'h8000_0002, 32'h8000_0003,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        directed.push_back(make_sample(3'd4, 32'h8000_0000, 32'h8000_0001,
                                       32'h8000_0002, 32'h8000_0003,
                                       32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        directed.push_back(make_sample(3'd2, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                                       32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        directed.push_back(make_sample(3'd3, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                                       32'h7FFF_FFFF, 32'h0000_0001, 1'b0));
        // sample on a node, and truncation of negative terms
        directed.push_back(make_sample(3'd3, 0, 32'h0001_0000, 32'h0002_0000, 0,
                                       32'hFFFF_0000, 32'h0001_0000, 1'b0));
        directed.push_back(make_sample(3'd4, 0, 3, 7, 11, 32'hFFFF_FFFD, 5, 1'b0));
        directed.push_back(make_sample(3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 2,
                                       32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
        directed.push_back('1);
        directed.push_back('0);

        foreach (directed[k]) send_sample(directed[k]);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_sample(random_sample());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS lagrange_element_eval");
        else
            $display("FAIL lagrange_element_eval");
        $finish;
    end

endmodule
